FILE: hw/rtl/qph_pkg.sv
// Package: shared constants, codes and types of the quadratic probe hash map.
package qph_pkg;

  localparam int unsigned CapacityDefault = 1024;

  // Built-in hash: (key ^ offset) * prime, where prime = 2^40 + 0x1b3
  localparam logic [63:0] HashOffset   = 64'hcbf29ce484222325;
  localparam logic [63:0] HashPrimeLow = 64'h1b3;
  localparam int unsigned HashPrimeSh  = 40;

  localparam logic OpLookup = 1'b0;
  localparam logic OpInsert = 1'b1;

  typedef enum logic [2:0] {
    StHit      = 3'd0,
    StMiss     = 3'd1,
    StInserted = 3'd2,
    StUpdated  = 3'd3,
    StFull     = 3'd4,
    StInvalid  = 3'd5
  } status_e;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

endpackage

FILE: hw/rtl/qph_chan_if.sv
// Interface: valid/ready channel carrying one item of type T.
interface qph_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/quadratic_probe_hash_map_unit.sv
// The key is hashed as the request is taken (and the hash is then reduced modulo
// CAPACITY if CAPACITY is not a power of two), then the back probes the key store
// through its read port, one read per probe, and registers the result for return.
// One item probes at a time, the next is hashed meanwhile. After reset the key
// store is swept to empty, one slot per cycle, before the first probe; requests
// queue up, configuration writes are taken at once. hash_mode resets to 0.
module quadratic_probe_hash_map_unit
  import qph_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qph_chan_if.sink   cfg_i,
  qph_chan_if.sink   req_i,
  qph_chan_if.source rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned QW = 2 + 64 + 64 + IW;

  logic          hash_mode_q;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;
  back_stat_t    stat;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      hash_mode_q <= cfg_i.data;
    end
  end

  qph_front #(.Capacity(CAPACITY)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hash_mode_i  (hash_mode_q),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  qph_fifo #(.Width(QW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  qph_back #(.Capacity(CAPACITY)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o),
    .stat_o      (stat)
  );

  // No request leaves the queue while the key store is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !(pop_valid && pop_ready))
    else $error("request popped during key store sweep");

  // Only a hit carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.status != StHit |-> rsp_o.data.read_value == 64'd0)
    else $error("nonzero read_value without a hit");

  // The back takes a new item only when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready |-> stat.idle)
    else $error("back accepted an item while busy");

endmodule

FILE: hw/rtl/qph_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qph_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/qph_fifo.sv
// Two-entry queue between the front and the back.
module qph_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

FILE: hw/rtl/qph_front.sv
// Front: accepts requests, hashes the key and reduces the hash to a start slot.
module qph_front
  import qph_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault,
  localparam int unsigned IW      = $clog2(Capacity),
  localparam int unsigned QW      = 2 + 64 + 64 + IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          hash_mode_i,
  qph_chan_if.sink      req_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output logic [QW-1:0] push_data_o
);

  localparam logic       IsPow2   = ((Capacity & (Capacity - 1)) == 0);
  localparam logic [3:0] NumBytes = 4'd8;
  localparam logic [IW:0] CapW    = (IW+1)'(Capacity);

  logic          busy_q;
  logic          op_q;
  logic [63:0]   key_q, val_q;
  logic [63:0]   h_q, h_d;
  logic [IW:0]   rem_q, rem_d;
  logic [3:0]    cnt_q;
  logic          done, push, accept;
  logic [63:0]   mixed, hval;
  logic [IW-1:0] idx;

  // Built-in hash, the prime split into a shift and a narrow constant
  assign mixed = req_i.data.key ^ HashOffset;
  assign hval  = hash_mode_i ? req_i.data.hash
                             : (mixed << HashPrimeSh) + 64'(mixed * HashPrimeLow);

  // Reduce eight hash bits per cycle, MSB first
  always_comb begin
    rem_d = rem_q;
    for (int b = 0; b < 8; b++) begin
      rem_d = {rem_d[IW-1:0], h_q[63-b]};
      if (rem_d >= CapW) rem_d = rem_d - CapW;
    end
    h_d = h_q << 8;
  end

  assign done   = busy_q && (IsPow2 || (cnt_q == NumBytes));
  assign idx    = IsPow2 ? h_q[IW-1:0] : rem_q[IW-1:0];
  assign push   = done && push_ready_i;
  assign accept = req_i.valid && req_i.ready;

  assign req_i.ready  = !busy_q || push;
  assign push_valid_o = done;
  assign push_data_o  = {(key_q == 64'd0), op_q, key_q, val_q, idx};

  // Hold the request and step the reduction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.data.op;
      key_q <= req_i.data.key;
      val_q <= req_i.data.value;
      h_q   <= hval;
      rem_q <= '0;
      cnt_q <= 4'd0;
    end else if (busy_q && !done) begin
      h_q   <= h_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (push) begin
      busy_q <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/qph_back.sv
// Back: clears the key store, walks the probe sequence and returns results.
module qph_back
  import qph_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault,
  localparam int unsigned IW      = $clog2(Capacity),
  localparam int unsigned QW      = 2 + 64 + 64 + IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [QW-1:0] pop_data_i,
  qph_chan_if.source    rsp_o,
  output back_stat_t    stat_o
);

  localparam logic [1:0] SClear = 2'd0;
  localparam logic [1:0] SIdle  = 2'd1;
  localparam logic [1:0] SProbe = 2'd2;
  localparam logic [1:0] SResp  = 2'd3;

  localparam logic [IW:0]   CapW    = (IW+1)'(Capacity);
  localparam logic [IW-1:0] LastIdx = IW'(Capacity - 1);
  localparam logic [IW-1:0] Limit   = IW'(Capacity / 2);

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] clr_q;
  logic [IW-1:0] idx_q, sq_q, inc_q, idx_nx, sq_nx, inc_nx;
  logic [IW:0]   probes_q, sum_i, sum_s, sum_c;
  logic [IW-1:0] count_q;
  logic          op_q;
  logic [63:0]   key_q, val_q;
  status_e       st_q, st_d;
  logic [63:0]   rv_q, rv_d;
  logic          ovalid_q;
  rsp_t          odata_q;
  logic          hd_inv, hd_op;
  logic [63:0]   hd_key, hd_val;
  logic [IW-1:0] hd_idx;
  logic          pop, adv, finish, ins, upd;
  logic [63:0]   key_rd, val_rd;
  logic          key_we, re;
  logic [IW-1:0] key_wa, raddr;
  logic [63:0]   key_wd;

  assign {hd_inv, hd_op, hd_key, hd_val, hd_idx} = pop_data_i;

  // Next probe position, square and odd step, each kept below capacity
  assign sum_i  = {1'b0, idx_q} + {1'b0, sq_q};
  assign sum_s  = {1'b0, sq_q} + {1'b0, inc_q};
  assign sum_c  = {1'b0, inc_q} + (IW+1)'(2);
  assign idx_nx = (sum_i >= CapW) ? IW'(sum_i - CapW) : sum_i[IW-1:0];
  assign sq_nx  = (sum_s >= CapW) ? IW'(sum_s - CapW) : sum_s[IW-1:0];
  assign inc_nx = (sum_c >= CapW) ? IW'(sum_c - CapW) : sum_c[IW-1:0];

  assign pop_ready_o = (state_q == SIdle);
  assign pop         = pop_valid_i && pop_ready_o;

  // Next state: key store sweep, taking an item, the probe outcome and the response
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    rv_d    = rv_q;
    adv     = 1'b0;
    finish  = 1'b0;
    ins     = 1'b0;
    upd     = 1'b0;
    unique case (state_q)
      SClear: begin
        if (clr_q == LastIdx) state_d = SIdle;
      end
      SIdle: begin
        if (pop) begin
          rv_d = 64'd0;
          if (hd_inv) begin
            st_d    = StInvalid;
            state_d = SResp;
          end else begin
            state_d = SProbe;
          end
        end
      end
      SProbe: begin
        finish = 1'b1;
        rv_d   = 64'd0;
        if (key_rd == key_q) begin
          if (op_q == OpLookup) begin
            st_d = StHit;
            rv_d = val_rd;
          end else begin
            st_d = StUpdated;
            upd  = 1'b1;
          end
        end else if (key_rd == 64'd0) begin
          if (op_q == OpLookup) begin
            st_d = StMiss;
          end else if (count_q >= Limit) begin
            st_d = StFull;
          end else begin
            st_d = StInserted;
            ins  = 1'b1;
          end
        end else if (probes_q == CapW) begin
          st_d = (op_q == OpLookup) ? StMiss : StFull;
        end else begin
          finish = 1'b0;
          adv    = 1'b1;
        end
        if (finish) state_d = SResp;
      end
      SResp: begin
        if (!ovalid_q || rsp_o.ready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Store ports
  assign key_we = (state_q == SClear) || ins;
  assign key_wa = (state_q == SClear) ? clr_q : idx_q;
  assign key_wd = (state_q == SClear) ? 64'd0 : key_q;
  assign re     = pop || adv;
  assign raddr  = (state_q == SIdle) ? hd_idx : idx_nx;

  qph_ram #(.Width(64), .Depth(Capacity)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_wa),
    .wdata_i (key_wd),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  qph_ram #(.Width(64), .Depth(Capacity)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ins || upd),
    .waddr_i (idx_q),
    .wdata_i (val_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (val_rd)
  );

  // Request and probe registers
  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rv_q <= rv_d;
    if (pop) begin
      op_q     <= hd_op;
      key_q    <= hd_key;
      val_q    <= hd_val;
      idx_q    <= hd_idx;
      sq_q     <= IW'(1);
      inc_q    <= IW'(3);
      probes_q <= (IW+1)'(1);
    end else if (adv) begin
      idx_q    <= idx_nx;
      sq_q     <= sq_nx;
      inc_q    <= inc_nx;
      probes_q <= probes_q + (IW+1)'(1);
    end
    if (state_q == SResp && (!ovalid_q || rsp_o.ready)) begin
      odata_q <= '{status: st_q, read_value: rv_q};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      clr_q    <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_q <= clr_q + IW'(1);
      if (ins) count_q <= count_q + IW'(1);
      if (state_q == SResp && (!ovalid_q || rsp_o.ready)) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid     = ovalid_q;
  assign rsp_o.data      = odata_q;
  assign stat_o.clearing = (state_q == SClear);
  assign stat_o.idle     = (state_q == SIdle);

endmodule
